/* rtl/page_frame_stack_allocator_core_macros.svh */
// Assertion macros for the page frame allocator core.
`ifndef PAGE_FRAME_STACK_ALLOCATOR_CORE_MACROS_SVH
`define PAGE_FRAME_STACK_ALLOCATOR_CORE_MACROS_SVH

// Property checked every cycle outside reset.
`define PFSA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define PFSA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/pfsa_pkg.sv */
// Shared widths, codes and defaults of the page frame allocator.
`default_nettype none
package pfsa_pkg;
  localparam int FRAME_W = 12;
  localparam int CNT_W = 13;
  localparam int FRAME_CAP = 4096;
  localparam int MAX_FRAMES_DEFAULT = 4096;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] TOTAL_FRAMES_RESET = 13'd4096;

  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ALREADY = 2'd1,
    ST_OOM     = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;
endpackage
`default_nettype wire

/* rtl/page_frame_stack_allocator_core.sv */
// Page frame allocator: free-frame LIFO in block RAM plus bump allocator.
// A transfer registers the request and reads the stack top; execute then writes the output register,
// stalling while it holds an untaken result. No new request is taken until the last leaves execute.
// A new request is taken while a finished result still waits at the output register.
// Reset (rst, synchronous): counters cleared, frame_total = 4096; stack RAM not cleared,
// its entries are only popped after a push has written them.
`default_nettype none
`include "page_frame_stack_allocator_core_macros.svh"
module page_frame_stack_allocator_core
  import pfsa_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // config: frame_total
  input  wire logic                  cfg_we,
  input  wire logic [CNT_W-1:0]      cfg_wdata,
  // request stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [11:0] page_frame, [12] kernel_page, [13] write_ok, [15:14] zero
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] command
  input  wire logic                  s_axis_tuser,
  // result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [11:0] frame_out, [12] present, [13] writable, [14] user_page,
  // [27:15] allocated_count, [31:28] zero
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // [1:0] status
  output logic [1:0]                 m_axis_tuser
);

  // Stack never holds more than the 4096-frame cap of the index field.
  localparam int STACK_DEPTH = (MAX_FRAMES < FRAME_CAP) ? MAX_FRAMES : FRAME_CAP;
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [CNT_W-1:0] LIMIT_CAP = CNT_W'(STACK_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;

  // configuration and allocator state
  logic [CNT_W-1:0] frame_total;
  logic [CNT_W-1:0] stack_fill, stack_fill_next;
  logic [CNT_W-1:0] next_unused, next_unused_next;
  logic [CNT_W-1:0] in_use, in_use_next;

  // free-frame stack RAM
  logic [FRAME_W-1:0] free_stack [STACK_DEPTH];
  logic [FRAME_W-1:0] rd_data;
  logic               mem_we;

  // latched request
  logic               cmd;
  logic [FRAME_W-1:0] pframe;
  logic               kern;
  logic               wr;

  logic in_fire, exec_fire;
  logic push_fire;
  logic out_present;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] fill_dec;
  logic [CNT_W-1:0] fill_inc;

  // execute results
  status_t            res_status;
  logic [FRAME_W-1:0] res_frame;
  logic               res_pres;

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  // execute retires only when the output register is free or draining
  assign exec_fire = (state == S_EXEC) && (!m_axis_tvalid || m_axis_tready);
  assign push_fire = exec_fire && mem_we;
  assign out_present = m_axis_tvalid && m_axis_tdata[FRAME_W];

  assign lim = (frame_total > LIMIT_CAP) ? LIMIT_CAP : frame_total;
  assign fill_dec = stack_fill - CNT_W'(1);
  assign fill_inc = stack_fill + CNT_W'(1);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (exec_fire) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    res_status       = ST_OK;
    res_frame        = '0;
    res_pres         = 1'b0;
    mem_we           = 1'b0;
    stack_fill_next  = stack_fill;
    next_unused_next = next_unused;
    in_use_next      = in_use;
    if (cmd == CMD_ALLOC) begin
      if (pframe != '0) begin
        res_status = ST_ALREADY;
        res_frame  = pframe;
      end else if (stack_fill != '0) begin
        // pop: rd_data holds stack[fill-1], read at transfer
        stack_fill_next = fill_dec;
        res_frame       = rd_data;
        res_pres        = 1'b1;
      end else if (next_unused >= lim) begin
        res_status = ST_OOM;
      end else begin
        // bump; first hand-out is frame 0 (reads back as unassigned)
        res_frame        = next_unused[FRAME_W-1:0];
        next_unused_next = next_unused + CNT_W'(1);
        res_pres         = 1'b1;
      end
      if (res_pres && in_use != CNT_MAX) in_use_next = in_use + CNT_W'(1);
    end else begin
      if (stack_fill >= lim) begin
        res_status = ST_FULL;
        res_frame  = pframe;
      end else begin
        mem_we          = 1'b1;
        stack_fill_next = fill_inc;
        if (in_use != '0) in_use_next = in_use - CNT_W'(1);
      end
    end
  end

  // RAM: one write (push at fill), one registered read (top at fill-1)
  always_ff @(posedge clk) begin
    if (push_fire) free_stack[stack_fill[AW-1:0]] <= pframe;
    if (in_fire) rd_data <= free_stack[fill_dec[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd    <= s_axis_tuser;
      pframe <= s_axis_tdata[FRAME_W-1:0];
      kern   <= s_axis_tdata[FRAME_W];
      wr     <= s_axis_tdata[FRAME_W+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      frame_total <= TOTAL_FRAMES_RESET;
      stack_fill  <= '0;
      next_unused <= '0;
      in_use      <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) frame_total <= cfg_wdata;
      if (exec_fire) begin
        stack_fill  <= stack_fill_next;
        next_unused <= next_unused_next;
        in_use      <= in_use_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (exec_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      m_axis_tuser <= res_status;
      m_axis_tdata <= {4'b0000, in_use_next, res_pres && !kern, res_pres && wr,
                       res_pres, res_frame};
    end
  end

  `PFSA_ASSERT_NEXT(a_accept_to_exec, in_fire, state == S_EXEC, "transfer did not enter execute")
  `PFSA_ASSERT(a_present_ok, !out_present || m_axis_tuser == ST_OK, "present on failed request")
  `PFSA_ASSERT_NEXT(a_push_grows, push_fire, stack_fill == $past(fill_inc), "stack did not grow")
  `PFSA_ASSERT(a_fill_cap, stack_fill <= LIMIT_CAP, "stack fill beyond capacity")

endmodule
`default_nettype wire

/* dv/tb.sv */
// Testbench for page_frame_stack_allocator_core: directed and random allocate/free traffic.
`timescale 1ns / 100ps

module tb;
  import pfsa_pkg::*;

  // Watchdog limit: cycles in a row with no transfer on either stream.
  localparam int STALL_LIMIT = 4000;
  // Length of the forced receiver stall used to back the block up.
  localparam int RX_HOLD_CYCLES = 150;
  localparam logic [CNT_W-1:0] POOL_CAP = CNT_W'(FRAME_CAP);

  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [CNT_W-1:0]   count_t;

  // One request, as the block sees it.
  typedef struct packed {
    cmd_t   cmd;
    frame_t page_frame;
    logic   kernel_page;
    logic   write_ok;
  } frame_req_t;

  // One answer, as the block returns it.
  typedef struct packed {
    status_t status;
    frame_t  frame_out;
    logic    present;
    logic    writable;
    logic    user_page;
    count_t  in_use;
  } frame_answer_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CNT_W-1:0]      cfg_wdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // [11:0] page_frame, [12] kernel_page, [13] write_ok, [15:14] zero
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // [0] command
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [11:0] frame_out, [12] present, [13] writable, [14] user_page,
  // [27:15] allocated_count, [31:28] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // [1:0] status
  logic [1:0]            m_axis_tuser;

  page_frame_stack_allocator_core DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Requests waiting for the driver, and predicted answers waiting for the block.
  frame_req_t    pending_reqs[$];
  frame_answer_t answers_due[$];

  // Shadow allocator state, updated at each request transfer.
  frame_t stack_mem[0:FRAME_CAP-1];
  count_t stack_fill;
  count_t bump_next;
  count_t frames_in_use;
  count_t pool_total;

  // Idle percentages of sender and receiver for the current phase.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  // Long receiver stalls: the stimulus bumps holds_asked, the receiver serves them.
  int unsigned holds_asked = 0;
  int unsigned holds_done;
  int unsigned hold_left;

  int unsigned reqs_issued = 0;
  int unsigned reqs_taken = 0;
  int unsigned answers_seen = 0;
  int unsigned error_count = 0;
  int unsigned oom_seen = 0;
  int unsigned full_seen = 0;
  int unsigned already_seen = 0;
  int unsigned phases_run = 0;
  int unsigned stall_cycles = 0;

  frame_req_t    cur_req;
  frame_answer_t got_answer;
  frame_answer_t want_answer;

  // Allocate pops the stack, then falls back to the bump pointer; free pushes.
  function automatic frame_answer_t allocate_or_free(input frame_req_t r);
    frame_answer_t a;
    count_t        lim;
    a = '0;
    a.status = ST_OK;
    lim = (pool_total > POOL_CAP) ? POOL_CAP : pool_total;
    if (r.cmd == CMD_ALLOC) begin
      if (r.page_frame != '0) begin
        a.status = ST_ALREADY;
        a.frame_out = r.page_frame;
      end else if (stack_fill != '0) begin
        // stack may still hold more than a shrunken limit; it drains anyway
        stack_fill = stack_fill - count_t'(1);
        a.frame_out = stack_mem[stack_fill[FRAME_W-1:0]];
        a.present = 1'b1;
      end else if (bump_next >= lim) begin
        a.status = ST_OOM;
      end else begin
        // first bump grant is frame 0, which reads back as "unassigned"
        a.frame_out = bump_next[FRAME_W-1:0];
        bump_next = bump_next + count_t'(1);
        a.present = 1'b1;
      end
      if (a.present) begin
        a.writable = r.write_ok;
        a.user_page = ~r.kernel_page;
        if (frames_in_use != CNT_MAX) frames_in_use = frames_in_use + count_t'(1);
      end
    end else begin
      if (stack_fill >= lim) begin
        a.status = ST_FULL;
        a.frame_out = r.page_frame;
      end else begin
        // frame 0 is pushed like any other
        stack_mem[stack_fill[FRAME_W-1:0]] = r.page_frame;
        stack_fill = stack_fill + count_t'(1);
        if (frames_in_use != '0) frames_in_use = frames_in_use - count_t'(1);
      end
    end
    a.in_use = frames_in_use;
    return a;
  endfunction

  task automatic flag_error(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      flag_error($sformatf("answer %0d %s = %0d, predicted %0d",
                           answers_seen, name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers pending requests, idles at random, predicts on each transfer.
  // The shadow config follows cfg_we at the same edge the block samples it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      stack_fill    = '0;
      bump_next     = '0;
      frames_in_use = '0;
      pool_total    = TOTAL_FRAMES_RESET;
    end else begin
      if (cfg_we) pool_total = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) begin
        answers_due.push_back(allocate_or_free(cur_req));
        reqs_taken++;
      end
      // Only move on once the current request is gone (or none is up).
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          cur_req = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {2'b00, cur_req.write_ok, cur_req.kernel_page,
                            cur_req.page_frame};
          s_axis_tuser  <= cur_req.cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random backpressure, plus long holds on request so the block
  // backs up and stalls its input while the driver keeps offering.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      holds_done    <= 0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      m_axis_tready <= 1'b0;
      hold_left     <= RX_HOLD_CYCLES;
      holds_done    <= holds_done + 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each answer transfer is checked against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_answer.status    = status_t'(m_axis_tuser);
      got_answer.frame_out = m_axis_tdata[11:0];
      got_answer.present   = m_axis_tdata[12];
      got_answer.writable  = m_axis_tdata[13];
      got_answer.user_page = m_axis_tdata[14];
      got_answer.in_use    = m_axis_tdata[27:15];
      if (answers_due.size() == 0) begin
        flag_error($sformatf("answer %0d arrived with no request outstanding",
                             answers_seen));
      end else begin
        want_answer = answers_due.pop_front();
        check_field("status", 32'(got_answer.status), 32'(want_answer.status));
        check_field("frame_out", 32'(got_answer.frame_out), 32'(want_answer.frame_out));
        check_field("present", 32'(got_answer.present), 32'(want_answer.present));
        check_field("writable", 32'(got_answer.writable), 32'(want_answer.writable));
        check_field("user_page", 32'(got_answer.user_page), 32'(want_answer.user_page));
        check_field("allocated_count", 32'(got_answer.in_use), 32'(want_answer.in_use));
        case (want_answer.status)
          ST_OOM:     oom_seen++;
          ST_FULL:    full_seen++;
          ST_ALREADY: already_seen++;
          default: ;
        endcase
      end
      answers_seen++;
    end
  end

  // Watchdog: a hung stream (or predictions never answered) ends the run.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("no transfer for %0d cycles, %0d answers still due",
               stall_cycles, answers_due.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_req(input cmd_t c, input frame_t pf, input logic k, input logic w);
    frame_req_t r;
    r.cmd = c;
    r.page_frame = pf;
    r.kernel_page = k;
    r.write_ok = w;
    pending_reqs.push_back(r);
    reqs_issued++;
  endtask

  // Sender pause: every request taken and every answer back.
  task automatic wait_drained();
    while (reqs_taken != reqs_issued || answers_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_total(input int unsigned total);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= count_t'(total);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly clean allocates (page_frame 0) and frees of frames near the pool;
  // the rest is double allocation and frees of arbitrary frame values.
  task automatic queue_random(input int unsigned n, input int unsigned alloc_pct,
                              input int unsigned span);
    cmd_t   c;
    frame_t pf;
    repeat (n) begin
      if ($urandom_range(99) < alloc_pct) begin
        c = CMD_ALLOC;
        pf = ($urandom_range(99) < 12) ? frame_t'($urandom_range(4095, 1)) : '0;
      end else begin
        c = CMD_FREE;
        case ($urandom_range(9))
          0:       pf = '0;
          1:       pf = '1;
          2, 3:    pf = frame_t'($urandom_range(4095));
          default: pf = frame_t'($urandom_range(span - 1));
        endcase
      end
      queue_req(c, pf, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  task automatic run_phase(input int unsigned total, input int unsigned n,
                           input int unsigned alloc_pct, input int unsigned tx_pct,
                           input int unsigned rx_pct);
    wait_drained();
    write_total(total);
    tx_idle_pct <= tx_pct;
    rx_idle_pct <= rx_pct;
    phases_run++;
    queue_random(n, alloc_pct, (total > 64) ? 64 : total);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Sender idles lightly, receiver heavily.
    tx_idle_pct <= 26;
    rx_idle_pct <= 81;

    // Directed: three-frame pool exercises every status and corner.
    write_total(3);
    queue_req(CMD_FREE,  12'h7FF, 1'b0, 1'b0); // free with nothing in use: count stays 0
    queue_req(CMD_ALLOC, 12'h000, 1'b0, 1'b1); // pops 0x7FF
    queue_req(CMD_ALLOC, 12'h000, 1'b0, 1'b1); // first bump grant is frame 0
    queue_req(CMD_ALLOC, 12'h000, 1'b1, 1'b0); // kernel, read-only
    queue_req(CMD_ALLOC, 12'hFFF, 1'b1, 1'b1); // already allocated, top frame
    queue_req(CMD_ALLOC, 12'h001, 1'b0, 1'b0); // already allocated, frame 1
    queue_req(CMD_ALLOC, 12'h000, 1'b1, 1'b1); // last bump frame
    queue_req(CMD_ALLOC, 12'h000, 1'b0, 1'b1); // out of memory
    queue_req(CMD_FREE,  12'h002, 1'b0, 1'b0);
    queue_req(CMD_FREE,  12'h000, 1'b1, 1'b0); // frame 0 is pushed too
    queue_req(CMD_FREE,  12'hFFF, 1'b1, 1'b1); // stack now at the limit
    queue_req(CMD_FREE,  12'h555, 1'b0, 1'b1); // pool full
    queue_req(CMD_ALLOC, 12'h000, 1'b1, 1'b1); // LIFO order: 0xFFF, 0, 2
    queue_req(CMD_ALLOC, 12'h000, 1'b0, 1'b0);
    queue_req(CMD_ALLOC, 12'h000, 1'b1, 1'b0);
    queue_req(CMD_ALLOC, 12'h000, 1'b0, 1'b1); // out of memory again
    wait_drained();
    // Smallest pool.
    write_total(1);
    queue_req(CMD_FREE,  12'hA5A, 1'b0, 1'b0);
    queue_req(CMD_FREE,  12'h5A5, 1'b1, 1'b1); // pool full at one entry
    queue_req(CMD_ALLOC, 12'h000, 1'b0, 1'b1);
    queue_req(CMD_ALLOC, 12'h000, 1'b1, 1'b0); // out of memory
    phases_run = 2;

    // Random phases; the pool shrinks below the stack depth more than once.
    run_phase(4096, 250, 65, 26, 81);
    run_phase(1,    150, 50, 26, 81);
    run_phase(40,   200, 50, 26, 81);

    // Sender idles heavily, receiver lightly; free-heavy to deepen the stack.
    run_phase(4096, 200, 30, 81, 26);
    run_phase(9,    150, 55, 81, 26);

    // No idling; a long receiver hold with the sender still pushing.
    run_phase(2500, 100, 50, 0, 0);
    holds_asked <= holds_asked + 1;
    wait_drained();
    queue_random(100, 55, 64);
    run_phase(64,   100, 50, 0, 0);

    // All requests out; wait for the answers, then let the bench settle.
    // Answers that never come are caught by the watchdog.
    wait_drained();
    repeat (10) @(posedge clk);

    $display("%0d requests over %0d pool sizes, %0d answers checked",
             reqs_taken, phases_run, answers_seen);
    $display("  %0d out of memory, %0d pool full, %0d already allocated, %0d errors",
             oom_seen, full_seen, already_seen, error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
